/* design/i2cmts_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmts_pkg: shared definitions of the I2C master transfer sequencer
// Operation codes, phase encoding, outcome codes, interrupt enable bits,
// configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned IrqW    = 3;
  localparam int unsigned OcW     = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  // read/write bit of the address byte
  localparam logic [ByteW-1:0] RwBit = 8'h01;

  // item operations
  localparam logic [OpW-1:0] OpBegin = 2'd0;
  localparam logic [OpW-1:0] OpEvent = 2'd1;
  localparam logic [OpW-1:0] OpError = 2'd2;
  localparam logic [OpW-1:0] OpAbort = 2'd3;

  // outcome codes
  localparam logic [OcW-1:0] OcNone     = 2'd0;
  localparam logic [OcW-1:0] OcComplete = 2'd1;
  localparam logic [OcW-1:0] OcError    = 2'd2;
  localparam logic [OcW-1:0] OcNackWait = 2'd3;

  // interrupt enable bits
  localparam logic [IrqW-1:0] EnEvt = 3'b001;
  localparam logic [IrqW-1:0] EnErr = 3'b010;
  localparam logic [IrqW-1:0] EnBuf = 3'b100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDevAddr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRegAddr  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReadDir  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSendReg  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLength   = 3'd4;

  // transfer phases, one-hot
  typedef enum logic [8:0] {
    PH_ADDR_TX   = 9'b0_0000_0001,
    PH_REG       = 9'b0_0000_0010,
    PH_RESTART   = 9'b0_0000_0100,
    PH_ADDR_RX   = 9'b0_0000_1000,
    PH_WAIT      = 9'b0_0001_0000,
    PH_READ      = 9'b0_0010_0000,
    PH_WRITE     = 9'b0_0100_0000,
    PH_END_WRITE = 9'b0_1000_0000,
    PH_COMPLETE  = 9'b1_0000_0000
  } phase_t;

  // one result record
  typedef struct packed {
    logic             drive_valid;
    logic [ByteW-1:0] drive_byte;
    logic             make_start;
    logic             make_stop;
    logic             ack_on;
    logic             store_valid;
    logic [ByteW-1:0] store_byte;
    logic [ByteW-1:0] byte_pos;
    logic [IrqW-1:0]  irq_enables;
    logic [OcW-1:0]   outcome;
  } result_t;

endpackage

/* design/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: master-side I2C register read/write sequencer
// Steps through address, register address, repeated start and data phases,
// one begin, bus event, error or abort item at a time.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is handled by the next-state rule, which
// reads the item and the phase, byte index, ACK and interrupt-enable
// registers; the result lands in the output register at the accepting edge.
// The input is ready whenever the output register is empty or being taken,
// so one item per cycle flows through as long as the result side keeps up;
// the result is valid in the cycle after acceptance. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata and should only
// change while no transfer is in flight.

module i2c_master_transfer_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration port
  input  logic                            cfg_we,
  input  logic [i2cmts_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [i2cmts_pkg::CfgW-1:0]     cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [i2cmts_pkg::OpW-1:0]      in_op,
  input  logic                            in_expected_event_seen,
  input  logic [i2cmts_pkg::ByteW-1:0]    in_received_byte,
  input  logic [i2cmts_pkg::ByteW-1:0]    in_send_byte,
  input  logic                            in_overrun_flag,
  input  logic                            in_bus_error_flag,
  input  logic                            in_nack_flag,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_valid,
  output logic [i2cmts_pkg::ByteW-1:0]    out_drive_byte,
  output logic                            out_make_start,
  output logic                            out_make_stop,
  output logic                            out_ack_on,
  output logic                            out_store_valid,
  output logic [i2cmts_pkg::ByteW-1:0]    out_store_byte,
  output logic [i2cmts_pkg::ByteW-1:0]    out_byte_pos,
  output logic [i2cmts_pkg::IrqW-1:0]     out_irq_enables,
  output logic [i2cmts_pkg::OcW-1:0]      out_outcome
);

  // configuration registers
  logic [i2cmts_pkg::ByteW-1:0] dev_addr_r;
  logic [i2cmts_pkg::ByteW-1:0] reg_addr_r;
  logic                         read_dir_r;
  logic                         send_reg_r;
  logic [i2cmts_pkg::ByteW-1:0] length_r;

  // sequencer state
  i2cmts_pkg::phase_t           phase_r, phase_nxt;
  logic [i2cmts_pkg::ByteW-1:0] idx_r, idx_nxt;
  logic                         ack_r, ack_nxt;
  logic [i2cmts_pkg::IrqW-1:0]  irq_r, irq_nxt;

  // result register
  logic                         out_valid_r;
  i2cmts_pkg::result_t          res_r, res_nxt;

  logic                         in_xfer;
  logic [i2cmts_pkg::ByteW-1:0] idx_inc;
  logic [i2cmts_pkg::ByteW:0]   idx_inc2;
  logic [i2cmts_pkg::ByteW-1:0] addr_wr;
  logic [i2cmts_pkg::ByteW-1:0] addr_rd;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
      reg_addr_r <= '0;
      read_dir_r <= 1'b0;
      send_reg_r <= 1'b0;
      length_r   <= i2cmts_pkg::ByteW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmts_pkg::RegDevAddr: dev_addr_r <= cfg_wdata;
        i2cmts_pkg::RegRegAddr: reg_addr_r <= cfg_wdata;
        i2cmts_pkg::RegReadDir: read_dir_r <= cfg_wdata[0];
        i2cmts_pkg::RegSendReg: send_reg_r <= cfg_wdata[0];
        i2cmts_pkg::RegLength:  length_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // index arithmetic and address bytes
  assign idx_inc  = idx_r + i2cmts_pkg::ByteW'(1);
  assign idx_inc2 = {1'b0, idx_inc} + (i2cmts_pkg::ByteW+1)'(1);
  assign addr_wr  = dev_addr_r & ~i2cmts_pkg::RwBit;
  assign addr_rd  = dev_addr_r | i2cmts_pkg::RwBit;

  // next-state rule
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ack_nxt   = ack_r;
    irq_nxt   = irq_r;
    res_nxt   = '0;

    case (in_op)
      i2cmts_pkg::OpBegin: begin
        if (phase_r == i2cmts_pkg::PH_COMPLETE) begin
          ack_nxt   = 1'b1;
          idx_nxt   = '0;
          phase_nxt = i2cmts_pkg::PH_ADDR_TX;
        end
        res_nxt.make_start = 1'b1;
        irq_nxt = irq_r | i2cmts_pkg::EnEvt | i2cmts_pkg::EnErr;
      end

      i2cmts_pkg::OpEvent: begin
        if (in_expected_event_seen) begin
          case (phase_r)
            i2cmts_pkg::PH_ADDR_TX: begin
              res_nxt.drive_valid = 1'b1;
              if (send_reg_r) begin
                res_nxt.drive_byte = addr_wr;
                phase_nxt = i2cmts_pkg::PH_REG;
              end else if (read_dir_r) begin
                res_nxt.drive_byte = addr_rd;
                phase_nxt = i2cmts_pkg::PH_WAIT;
              end else begin
                res_nxt.drive_byte = addr_wr;
                phase_nxt = i2cmts_pkg::PH_WRITE;
              end
            end
            i2cmts_pkg::PH_REG: begin
              res_nxt.drive_valid = 1'b1;
              res_nxt.drive_byte  = reg_addr_r;
              if (read_dir_r) begin
                phase_nxt = i2cmts_pkg::PH_RESTART;
              end else begin
                irq_nxt   = irq_r | i2cmts_pkg::EnBuf;
                phase_nxt = i2cmts_pkg::PH_WRITE;
              end
            end
            i2cmts_pkg::PH_RESTART: begin
              res_nxt.make_start = 1'b1;
              phase_nxt = i2cmts_pkg::PH_ADDR_RX;
            end
            i2cmts_pkg::PH_ADDR_RX: begin
              res_nxt.drive_valid = 1'b1;
              res_nxt.drive_byte  = addr_rd;
              if (length_r == i2cmts_pkg::ByteW'(1)) begin
                ack_nxt = 1'b0;
              end
              phase_nxt = i2cmts_pkg::PH_WAIT;
            end
            i2cmts_pkg::PH_WAIT: begin
              irq_nxt   = irq_r | i2cmts_pkg::EnBuf;
              phase_nxt = i2cmts_pkg::PH_READ;
            end
            i2cmts_pkg::PH_READ: begin
              res_nxt.store_valid = 1'b1;
              res_nxt.store_byte  = in_received_byte;
              res_nxt.byte_pos    = idx_r;
              idx_nxt = idx_inc;
              // NACK the last byte, finish after it arrives
              if (idx_inc2 == {1'b0, length_r}) begin
                ack_nxt = 1'b0;
              end else if (idx_inc == length_r) begin
                irq_nxt   = '0;
                res_nxt.make_stop = 1'b1;
                phase_nxt = i2cmts_pkg::PH_COMPLETE;
                res_nxt.outcome = i2cmts_pkg::OcComplete;
              end
            end
            i2cmts_pkg::PH_WRITE: begin
              res_nxt.drive_valid = 1'b1;
              res_nxt.drive_byte  = in_send_byte;
              res_nxt.byte_pos    = idx_r;
              idx_nxt = idx_inc;
              if (idx_inc == length_r) begin
                irq_nxt   = irq_r & ~i2cmts_pkg::EnBuf;
                phase_nxt = i2cmts_pkg::PH_END_WRITE;
              end
            end
            i2cmts_pkg::PH_END_WRITE: begin
              irq_nxt   = '0;
              res_nxt.make_stop = 1'b1;
              phase_nxt = i2cmts_pkg::PH_COMPLETE;
              res_nxt.outcome = i2cmts_pkg::OcComplete;
            end
            default: begin
              // spurious event when idle
              irq_nxt = irq_r & ~(i2cmts_pkg::EnEvt | i2cmts_pkg::EnBuf);
            end
          endcase
        end else if (phase_r == i2cmts_pkg::PH_COMPLETE) begin
          irq_nxt = irq_r & ~(i2cmts_pkg::EnEvt | i2cmts_pkg::EnBuf);
        end
      end

      i2cmts_pkg::OpError: begin
        if (phase_r == i2cmts_pkg::PH_COMPLETE) begin
          irq_nxt = irq_r & ~i2cmts_pkg::EnErr;
        end else if (in_nack_flag && phase_r == i2cmts_pkg::PH_WAIT) begin
          // step back and pause
          phase_nxt = i2cmts_pkg::PH_ADDR_RX;
          irq_nxt   = '0;
          res_nxt.outcome = i2cmts_pkg::OcNackWait;
        end else if (in_nack_flag && phase_r == i2cmts_pkg::PH_REG) begin
          phase_nxt = i2cmts_pkg::PH_ADDR_TX;
          irq_nxt   = '0;
          res_nxt.outcome = i2cmts_pkg::OcNackWait;
        end else begin
          // overrun, bus error or late nack ends the transfer
          irq_nxt   = '0;
          res_nxt.make_stop = 1'b1;
          phase_nxt = i2cmts_pkg::PH_COMPLETE;
          res_nxt.outcome = i2cmts_pkg::OcError;
        end
      end

      default: begin
        // abort
        irq_nxt   = '0;
        res_nxt.make_stop = 1'b1;
        phase_nxt = i2cmts_pkg::PH_COMPLETE;
      end
    endcase

    res_nxt.ack_on      = ack_nxt;
    res_nxt.irq_enables = irq_nxt;
  end

  // state update on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cmts_pkg::PH_COMPLETE;
      idx_r   <= '0;
      ack_r   <= 1'b0;
      irq_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      ack_r   <= ack_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  // the flag inputs only steer the error branch through nack
  logic unused_flags;
  assign unused_flags = in_overrun_flag ^ in_bus_error_flag;

  // outputs
  assign out_valid       = out_valid_r;
  assign out_drive_valid = res_r.drive_valid;
  assign out_drive_byte  = res_r.drive_byte;
  assign out_make_start  = res_r.make_start;
  assign out_make_stop   = res_r.make_stop;
  assign out_ack_on      = res_r.ack_on;
  assign out_store_valid = res_r.store_valid;
  assign out_store_byte  = res_r.store_byte;
  assign out_byte_pos    = res_r.byte_pos;
  assign out_irq_enables = res_r.irq_enables;
  assign out_outcome     = res_r.outcome;

endmodule

/* design/i2cmts_checker.sv */
// ----------------------------------------------------------------------------
// i2cmts_checker: port-level checks of the I2C master transfer sequencer
// Watches the result channel and flags results that the sequencer can
// never produce, plus a stalled result that changes.
// ----------------------------------------------------------------------------
module i2cmts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_drive_valid,
  input logic [i2cmts_pkg::ByteW-1:0]  out_drive_byte,
  input logic                          out_make_start,
  input logic                          out_make_stop,
  input logic                          out_store_valid,
  input logic [i2cmts_pkg::IrqW-1:0]   out_irq_enables,
  input logic [i2cmts_pkg::OcW-1:0]    out_outcome
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_byte)
      && $stable(out_outcome) && $stable(out_irq_enables))
    else $error("result changed while stalled");

  // start and stop never come from the same transfer
  a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_make_start && out_make_stop))
    else $error("start and stop in one result");

  // a received byte never comes with a byte to transmit
  a_store_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |-> !out_drive_valid && out_drive_byte == '0)
    else $error("store and drive in one result");

  // a finished or failed transfer issues a stop and masks interrupts
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == i2cmts_pkg::OcComplete
                  || out_outcome == i2cmts_pkg::OcError)
      |-> out_make_stop && out_irq_enables == '0)
    else $error("transfer ended without stop or with interrupts enabled");

  // a nack pause masks interrupts and leaves the bus held
  a_pause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == i2cmts_pkg::OcNackWait
      |-> !out_make_stop && out_irq_enables == '0)
    else $error("nack pause with stop or interrupts enabled");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_drive_valid (out_drive_valid),
  .out_drive_byte  (out_drive_byte),
  .out_make_start  (out_make_start),
  .out_make_stop   (out_make_stop),
  .out_store_valid (out_store_valid),
  .out_irq_enables (out_irq_enables),
  .out_outcome     (out_outcome)
);
